>>> rtl/p4t_pkg.sv
`default_nettype none

package p4t_pkg;

  // Fixed sizes of the transmitter.
  localparam int TAPS              = 3;
  localparam int TAP_FRAC_BITS_DEF = 16;
  localparam int LFSR_W            = 31;
  localparam int SYM_W             = 2;
  localparam int LVL_W             = 3;
  localparam int RAW_TAP_W         = 16;
  localparam int L1_W              = 17;
  localparam int DRIVE_W           = 18;
  localparam int DRIVE_FRAC        = 16;
  localparam int DRIVE_FULL        = 65536;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 32;

  localparam logic [LFSR_W-1:0]    DEFAULT_SEED = LFSR_W'(32'h5EED);
  localparam logic [RAW_TAP_W-1:0] CENTER_RAW   = RAW_TAP_W'(32768);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SEED     = 2'd0,
    REG_PRE_TAP  = 2'd1,
    REG_POST_TAP = 2'd2
  } reg_idx_t;

  typedef logic signed [LVL_W-1:0] level_t;

  // PAM4 level in thirds of full scale: 2*symbol - 3.
  function automatic level_t sym_to_level(input logic [SYM_W-1:0] sym);
    level_t lvl;
    case (sym)
      2'd0:    lvl = -3'sd3;
      2'd1:    lvl = -3'sd1;
      2'd2:    lvl = 3'sd1;
      default: lvl = 3'sd3;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/p4t_rdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller adds any
// rounding offset to the numerator before start.
module p4t_rdiv #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             rem_ge;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // One long-division step: shift in the next numerator bit and subtract.
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    rem_ge   = (rem_sh >= {1'b0, den_r});
    rem_nxt  = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    num_nxt  = {num_r[NUM_W-2:0], 1'b0};
    quo_nxt  = {quo_r[NUM_W-2:0], rem_ge};
  end

  // Step counter and status.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/pam4_prbs31_ffe_transmitter.sv
`default_nettype none

// Channel  | Handshake                       | Payload
// ---------+---------------------------------+-------------------------------
// input    | in_valid / in_ready             | in_tick
// result   | out_valid / out_ready           | out_symbol, out_drive
// config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One transaction per cycle is accepted while in_ready is high; a result is
// held in the first stage (LFSR and tap sum), then in the output stage (scaling).
// A transaction with tick low is consumed and produces no result.
// Writing pre_tap or post_tap holds in_ready low while the taps are renormalized:
// 16 + TAP_FRAC_BITS divider steps, one quotient bit each, and then the tap load.
// Reset is synchronous; a stalled result keeps the next item in the first stage.
module pam4_prbs31_ffe_transmitter #(
  parameter int TAP_FRAC_BITS = p4t_pkg::TAP_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_tick,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [p4t_pkg::SYM_W-1:0]          out_symbol,
  output logic signed [p4t_pkg::DRIVE_W-1:0] out_drive,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [p4t_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [p4t_pkg::PDATA_W-1:0]   pwdata,
  output logic [p4t_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  import p4t_pkg::*;

  localparam int TAP_W   = TAP_FRAC_BITS + 2;
  localparam int NUM_W   = RAW_TAP_W + TAP_FRAC_BITS;
  localparam int ACC_W   = TAP_FRAC_BITS + 4;
  localparam int MAG_W   = ACC_W - 1;
  localparam int SUM_W   = MAG_W + DRIVE_FRAC + 1;
  localparam int T_W     = SUM_W - TAP_FRAC_BITS;
  localparam int RCP_SH  = T_W + 1;
  localparam int Q_W     = 2 * T_W - RCP_SH;
  localparam int MAGD_W  = DRIVE_W - 1;

  localparam logic [T_W-1:0]   RECIP   = T_W'(((64'd1 << RCP_SH) + 64'd2) / 64'd3);
  localparam logic [SUM_W-1:0] RND_ADD = SUM_W'(3) << (TAP_FRAC_BITS - 1);
  localparam logic signed [TAP_W-1:0] TAP_ONE = TAP_W'(1) << TAP_FRAC_BITS;

  // Configuration registers.
  logic [LFSR_W-1:0]           seed_r;
  logic signed [RAW_TAP_W-1:0] pre_tap_r;
  logic signed [RAW_TAP_W-1:0] post_tap_r;

  // Transmit state.
  logic [LFSR_W-1:0]       lfsr_r, lfsr_nxt;
  level_t                  hist_r [TAPS-1];
  logic signed [TAP_W-1:0] tap_r [TAPS];

  // Pipeline registers.
  logic                    s1_valid_r, s1_valid_nxt;
  logic [SYM_W-1:0]        s1_sym_r;
  logic signed [ACC_W-1:0] s1_acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]        out_symbol_r;
  logic signed [DRIVE_W-1:0] out_drive_r, drive_nxt;

  // Handshake and configuration decode.
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     wr_seed, wr_pre, wr_post, wr_tap;
  logic     in_fire, s2_load, s1_free, norm_busy;

  // Divider connections.
  logic [RAW_TAP_W-1:0] pre_src, post_src;
  logic [RAW_TAP_W-1:0] raw_mag [TAPS];
  logic [L1_W-1:0]      l1_sum;
  logic [NUM_W-1:0]     div_num [TAPS];
  logic [NUM_W-1:0]     div_quo [TAPS];
  logic [TAPS-1:0]      div_busy;
  logic [TAPS-1:0]      div_done;
  logic [TAPS-1:0]      tap_neg;

  // Stage-one datapath.
  logic [SYM_W-1:0]        sym_nxt;
  level_t                  lvl_new;
  level_t                  lvl_win [TAPS];
  logic signed [ACC_W-1:0] tap_x1, tap_x3;
  logic signed [ACC_W-1:0] term [TAPS];

  // Stage-two datapath.
  logic                 acc_neg;
  logic [MAG_W-1:0]     acc_mag;
  logic [SUM_W-1:0]     rnd_sum;
  logic [T_W-1:0]       t_val;
  logic [2*T_W-1:0]     rcp_prod;
  logic [Q_W-1:0]       q_val;
  logic [MAGD_W-1:0]    q_sat;

  // Configuration port decode.
  always_comb begin
    cfg_wr  = psel && penable && pwrite;
    cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    wr_seed = 1'b0;
    wr_pre  = 1'b0;
    wr_post = 1'b0;
    case (cfg_idx)
      REG_SEED:     wr_seed = cfg_wr;
      REG_PRE_TAP:  wr_pre  = cfg_wr;
      REG_POST_TAP: wr_post = cfg_wr;
      default:      ;
    endcase
    wr_tap = wr_pre || wr_post;
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_SEED:     prdata = PDATA_W'(seed_r);
      REG_PRE_TAP:  prdata = PDATA_W'(pre_tap_r);
      REG_POST_TAP: prdata = PDATA_W'(post_tap_r);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      pre_tap_r  <= '0;
      post_tap_r <= '0;
    end else begin
      if (wr_seed) begin
        seed_r <= pwdata[LFSR_W-1:0];
      end
      if (wr_pre) begin
        pre_tap_r <= pwdata[RAW_TAP_W-1:0];
      end
      if (wr_post) begin
        post_tap_r <= pwdata[RAW_TAP_W-1:0];
      end
    end
  end

  // L1 normalization operands use the value being written this cycle.
  always_comb begin
    pre_src  = wr_pre  ? pwdata[RAW_TAP_W-1:0] : pre_tap_r;
    post_src = wr_post ? pwdata[RAW_TAP_W-1:0] : post_tap_r;
    raw_mag[0] = pre_src[RAW_TAP_W-1] ? -pre_src : pre_src;
    raw_mag[1] = CENTER_RAW;
    raw_mag[2] = post_src[RAW_TAP_W-1] ? -post_src : post_src;
    l1_sum = L1_W'(raw_mag[0]) + L1_W'(raw_mag[1]) + L1_W'(raw_mag[2]);
    for (int i = 0; i < TAPS; i++) begin
      div_num[i] = {raw_mag[i], {TAP_FRAC_BITS{1'b0}}} + NUM_W'(l1_sum >> 1);
    end
    tap_neg[0] = pre_tap_r[RAW_TAP_W-1];
    tap_neg[1] = 1'b0;
    tap_neg[2] = post_tap_r[RAW_TAP_W-1];
  end

  // One serial divider per tap; all three share the L1 denominator.
  for (genvar g = 0; g < TAPS; g++) begin : g_div
    p4t_rdiv #(
      .NUM_W (NUM_W),
      .DEN_W (L1_W)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (wr_tap),
      .num   (div_num[g]),
      .den   (l1_sum),
      .busy  (div_busy[g]),
      .done  (div_done[g]),
      .quo   (div_quo[g])
    );
  end

  // The taps change at the end of the done cycle, so that cycle is busy too.
  assign norm_busy = (|div_busy) || (|div_done);

  // Pipeline flow control.
  always_comb begin
    s2_load       = s1_valid_r && (!out_valid_r || out_ready);
    s1_free       = !s1_valid_r || s2_load;
    in_ready      = s1_free && !norm_busy;
    in_fire       = in_valid && in_ready;
    s1_valid_nxt  = (in_fire && in_tick) ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Two LFSR steps per symbol; the first feedback bit is the MSB.
  always_comb begin
    sym_nxt  = {lfsr_r[30] ^ lfsr_r[27], lfsr_r[29] ^ lfsr_r[26]};
    lfsr_nxt = {lfsr_r[LFSR_W-3:0], sym_nxt};
    lvl_new  = sym_to_level(sym_nxt);
  end

  // FFE sum over the level window; each level is +-1 or +-3, or 0 in a cleared history slot.
  always_comb begin
    lvl_win[0] = lvl_new;
    for (int i = 1; i < TAPS; i++) begin
      lvl_win[i] = hist_r[i-1];
    end
    tap_x1 = '0;
    tap_x3 = '0;
    for (int i = 0; i < TAPS; i++) begin
      tap_x1 = ACC_W'(tap_r[i]);
      tap_x3 = tap_x1 + (tap_x1 <<< 1);
      case (lvl_win[i])
        3'sd1:   term[i] = tap_x1;
        -3'sd1:  term[i] = -tap_x1;
        3'sd3:   term[i] = tap_x3;
        -3'sd3:  term[i] = -tap_x3;
        default: term[i] = '0;
      endcase
    end
    acc_nxt = term[0] + term[1] + term[2];
  end

  // Scale to Q.16, divide by three with round half away, saturate.
  always_comb begin
    acc_neg  = s1_acc_r[ACC_W-1];
    acc_mag  = acc_neg ? MAG_W'(-s1_acc_r) : MAG_W'(s1_acc_r);
    rnd_sum  = SUM_W'({acc_mag, {DRIVE_FRAC{1'b0}}}) + RND_ADD;
    t_val    = rnd_sum[SUM_W-1:TAP_FRAC_BITS];
    rcp_prod = (2*T_W)'(t_val) * (2*T_W)'(RECIP);
    q_val    = rcp_prod[2*T_W-1:RCP_SH];
    q_sat    = (q_val > Q_W'(DRIVE_FULL)) ? MAGD_W'(DRIVE_FULL) : MAGD_W'(q_val);
    drive_nxt = acc_neg ? -DRIVE_W'(q_sat) : DRIVE_W'(q_sat);
  end

  // Control state: LFSR, history, taps and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= DEFAULT_SEED;
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_r[i] <= '0;
      end
      tap_r[0]    <= '0;
      tap_r[1]    <= TAP_ONE;
      tap_r[2]    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_seed) begin
        lfsr_r <= (pwdata[LFSR_W-1:0] == '0) ? DEFAULT_SEED : pwdata[LFSR_W-1:0];
      end else if (in_fire && in_tick) begin
        lfsr_r <= lfsr_nxt;
      end
      if (wr_tap) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          hist_r[i] <= '0;
        end
      end else if (in_fire && in_tick) begin
        hist_r[0] <= lvl_new;
        for (int i = 1; i < TAPS - 1; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
      for (int i = 0; i < TAPS; i++) begin
        if (div_done[i]) begin
          tap_r[i] <= tap_neg[i] ? -TAP_W'(div_quo[i]) : TAP_W'(div_quo[i]);
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && in_tick) begin
      s1_sym_r <= sym_nxt;
      s1_acc_r <= acc_nxt;
    end
    if (s2_load) begin
      out_symbol_r <= s1_sym_r;
      out_drive_r  <= drive_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_drive  = out_drive_r;

  // No transaction is taken while the taps are being renormalized.
  a_no_accept_norm: assert property (@(posedge clk) disable iff (!rst_n)
    wr_tap |=> !in_ready)
    else $error("input accepted during tap renormalization");

  // A result in the first stage moves out when the output register is free.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("first stage result did not advance");

  // The drive never leaves full scale.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r <= DRIVE_W'(DRIVE_FULL) &&
                     out_drive_r >= -DRIVE_W'(DRIVE_FULL)))
    else $error("drive outside full scale");

  // A tap write clears the level history.
  a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
    wr_tap |=> (hist_r[0] == '0 && hist_r[1] == '0))
    else $error("history not cleared by tap write");

endmodule

`default_nettype wire
